// File: rtl/core/ilir_pkg.sv
`default_nettype none

package ilir_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    // request codes on s_action
    typedef enum logic [ACTION_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_REMOVE = 3'd4
    } action_t;

    // result codes on m_status
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_INDEX = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SET    = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [WORD_W-1:0]   value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/indexed_list_insert_remove.sv
// indexed list engine: an ordered list of signed 32-bit words, CAPACITY deep
//
// s_ channel carries one request beat: action, index, value
//   get, set, append, insert at index, remove at index
// m_ channel returns one result beat per request: read_value, status, count
//   read_value holds the word for get and remove, zero otherwise
//   status is done, index out of range, or list full; on error nothing changes
//
// the list lives in a row of cells, one word each; insert and remove move
// every later word by one place in the same cycle through neighbor links
//
// a request passes the request register, the cell update and the registered
// read select before its result beat; a new request is taken only after the
// previous one has reached the result register
//
// reset empties the list (count zero); cell contents stay undefined
// a stalled receiver holds the result register; one more request is taken
// and waits, finished, until the result register frees up
`default_nettype none

module indexed_list_insert_remove #(
    parameter int CAPACITY = 64,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [ilir_pkg::ACTION_W-1:0]          s_action,
    input  wire logic [CW-1:0]                          s_index,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]     s_value,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [ilir_pkg::WORD_W-1:0]          m_read_value,
    output logic [ilir_pkg::STATUS_W-1:0]               m_status,
    output logic [CW-1:0]                               m_count
);
    import ilir_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEL
    } state_t;

    state_t                     state_reg, state_next;
    logic [ACTION_W-1:0]        act_reg, act_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic signed [WORD_W-1:0]   val_reg, val_next;
    logic [CW-1:0]              count_reg, count_next;
    status_t                    st_reg, st_next;
    logic                       rd_use_reg, rd_use_next;

    logic                       m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0]   m_read_value_reg, m_read_value_next;
    logic [STATUS_W-1:0]        m_status_reg, m_status_next;
    logic [CW-1:0]              m_count_reg, m_count_next;

    cell_cmd_t                  cmd;
    logic [CW-1:0]              cell_index;
    logic signed [WORD_W-1:0]   cell_word [CAPACITY];
    logic signed [WORD_W-1:0]   rd_word;

    logic                       idx_lt, idx_le, is_full, out_free;

    assign idx_lt   = idx_reg < count_reg;
    assign idx_le   = idx_reg <= count_reg;
    assign is_full  = count_reg == CW'(CAPACITY);
    assign out_free = !m_valid_reg || m_ready;

    // request decode and list control
    always_comb begin
        state_next        = state_reg;
        act_next          = act_reg;
        idx_next          = idx_reg;
        val_next          = val_reg;
        count_next        = count_reg;
        st_next           = st_reg;
        rd_use_next       = rd_use_reg;
        m_valid_next      = m_valid_reg;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        cmd.op            = CELL_HOLD;
        cmd.value         = val_reg;
        cell_index        = idx_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    idx_next   = s_index;
                    val_next   = s_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                st_next     = STATUS_DONE;
                rd_use_next = 1'b0;
                // value register is free after this cycle; it is cleared, and holds the read word if the result stalls
                val_next    = '0;
                unique case (act_reg)
                    ACT_GET: begin
                        if (idx_lt) rd_use_next = 1'b1;
                        else st_next = STATUS_INDEX;
                    end
                    ACT_SET: begin
                        if (idx_lt) cmd.op = CELL_SET;
                        else st_next = STATUS_INDEX;
                    end
                    ACT_APPEND: begin
                        if (is_full) begin
                            st_next = STATUS_FULL;
                        end else begin
                            cmd.op     = CELL_SET;
                            cell_index = count_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_INSERT: begin
                        if (!idx_le) begin
                            st_next = STATUS_INDEX;
                        end else if (is_full) begin
                            st_next = STATUS_FULL;
                        end else begin
                            cmd.op     = CELL_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_REMOVE: begin
                        if (idx_lt) begin
                            cmd.op      = CELL_REMOVE;
                            rd_use_next = 1'b1;
                            count_next  = count_reg - CW'(1);
                        end else begin
                            st_next = STATUS_INDEX;
                        end
                    end
                    default: begin
                        st_next = STATUS_DONE;
                    end
                endcase
                state_next = S_SEL;
            end
            S_SEL: begin
                // read select is registered; result waits here if m_ stalls
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = rd_use_reg ? rd_word : val_reg;
                    m_status_next     = st_reg;
                    m_count_next      = count_reg;
                    state_next        = S_IDLE;
                end else if (rd_use_reg) begin
                    // keep the word read before a remove shifted the row
                    val_next    = rd_word;
                    rd_use_next = 1'b0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg          <= act_next;
        idx_reg          <= idx_next;
        val_reg          <= val_next;
        st_reg           <= st_next;
        rd_use_reg       <= rd_use_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
        m_count_reg      <= m_count_next;
    end

    // row of cells; each sees its lower and upper neighbor
    genvar p;
    generate
        for (p = 0; p < CAPACITY; p++) begin : g_cell
            logic signed [WORD_W-1:0] prev_w, next_w;
            if (p == 0) begin : g_first
                assign prev_w = '0;
            end else begin : g_prev
                assign prev_w = cell_word[p-1];
            end
            if (p == CAPACITY - 1) begin : g_last
                assign next_w = '0;
            end else begin : g_next
                assign next_w = cell_word[p+1];
            end
            ilir_cell #(
                .POS (p),
                .CW  (CW)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .sel_index (cell_index),
                .prev_word (prev_w),
                .next_word (next_w),
                .word      (cell_word[p])
            );
        end
    endgenerate

    // samples the row before the cell update of the same edge
    ilir_read_sel #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_read_sel (
        .aclk     (aclk),
        .words    (cell_word),
        .rd_index (idx_reg[IW-1:0]),
        .rd_word  (rd_word)
    );

    assign s_ready      = state_reg == S_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/ilir_cell.sv
`default_nettype none

module ilir_cell #(
    parameter int POS = 0,
    parameter int CW  = 7
) (
    input  wire logic                                   aclk,
    input  wire ilir_pkg::cell_cmd_t                    cmd,
    input  wire logic [CW-1:0]                          sel_index,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]     prev_word,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]     next_word,
    output logic signed [ilir_pkg::WORD_W-1:0]          word
);
    import ilir_pkg::*;

    localparam logic [CW-1:0] POS_C = CW'(POS);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        case (cmd.op)
            CELL_SET: begin
                if (sel_index == POS_C) word_next = cmd.value;
            end
            CELL_INSERT: begin
                // new word lands here, later words move up one place
                if (sel_index == POS_C) word_next = cmd.value;
                else if (POS_C > sel_index) word_next = prev_word;
            end
            CELL_REMOVE: begin
                if (POS_C >= sel_index) word_next = next_word;
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: rtl/core/ilir_read_sel.sv
`default_nettype none

module ilir_read_sel #(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
) (
    input  wire logic                                   aclk,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]     words [CAPACITY],
    input  wire logic [IW-1:0]                          rd_index,
    output logic signed [ilir_pkg::WORD_W-1:0]          rd_word
);
    import ilir_pkg::*;

    // first stage picks within groups of up to 32, second stage across groups
    localparam int GW    = (IW > 5) ? 5 : IW;
    localparam int G     = 1 << GW;
    localparam int NGRP  = 1 << (IW - GW);
    localparam int TOTAL = NGRP * G;

    logic signed [WORD_W-1:0] pad_word [TOTAL];
    logic signed [WORD_W-1:0] grp_reg  [NGRP];

    genvar k, g;
    generate
        for (k = 0; k < TOTAL; k++) begin : g_pad
            if (k < CAPACITY) begin : g_live
                assign pad_word[k] = words[k];
            end else begin : g_fill
                assign pad_word[k] = '0;
            end
        end

        for (g = 0; g < NGRP; g++) begin : g_grp
            logic signed [WORD_W-1:0] slice [G];
            for (k = 0; k < G; k++) begin : g_slice
                assign slice[k] = pad_word[g*G + k];
            end
            always_ff @(posedge aclk) begin
                grp_reg[g] <= slice[rd_index[GW-1:0]];
            end
        end

        if (IW > GW) begin : g_multi
            logic [IW-GW-1:0] hi_reg;
            always_ff @(posedge aclk) begin
                hi_reg <= rd_index[IW-1:GW];
            end
            assign rd_word = grp_reg[hi_reg];
        end else begin : g_single
            assign rd_word = grp_reg[0];
        end
    endgenerate

endmodule

`default_nettype wire

// File: bench/ilir_list_checker.sv
`timescale 1ns / 100ps

module ilir_list_checker #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [ilir_pkg::ACTION_W-1:0]       s_action,
    input  logic [CW-1:0]                       s_index,
    input  logic signed [ilir_pkg::WORD_W-1:0]  s_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [ilir_pkg::WORD_W-1:0]  m_read_value,
    input  logic [ilir_pkg::STATUS_W-1:0]       m_status,
    input  logic [CW-1:0]                       m_count,
    output int                                  fail_count,
    output int                                  replies_owed,
    output int                                  list_len
);
    import ilir_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0]   read_value;
        status_t                    status;
        logic [CW-1:0]              count;
    } list_reply_t;

    logic signed [WORD_W-1:0]   words [CAPACITY];
    int                         n_words;
    int                         reply_beats;
    list_reply_t                reply_q [$];

    // applies one request to the shadow list and returns the reply it owes
    function automatic list_reply_t predict_list_op(action_t op, int pos,
                                                    logic signed [WORD_W-1:0] word);
        list_reply_t r;
        int i;
        r.read_value = '0;
        r.status     = STATUS_DONE;
        case (op)
            ACT_GET: begin
                if (pos < n_words) r.read_value = words[pos];
                else r.status = STATUS_INDEX;
            end
            ACT_SET: begin
                if (pos < n_words) words[pos] = word;
                else r.status = STATUS_INDEX;
            end
            ACT_APPEND: begin
                if (n_words >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    words[n_words] = word;
                    n_words++;
                end
            end
            ACT_INSERT: begin
                // index error wins over full
                if (pos > n_words) begin
                    r.status = STATUS_INDEX;
                end else if (n_words >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (i = n_words; i > pos; i--) words[i] = words[i-1];
                    words[pos] = word;
                    n_words++;
                end
            end
            ACT_REMOVE: begin
                if (pos < n_words) begin
                    r.read_value = words[pos];
                    for (i = pos; i + 1 < n_words; i++) words[i] = words[i+1];
                    n_words--;
                end else begin
                    r.status = STATUS_INDEX;
                end
            end
            default: ;
        endcase
        r.count = CW'(n_words);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_reply_t got;
        list_reply_t want;
        if (!aresetn) begin
            n_words     = 0;
            reply_beats = 0;
            fail_count  = 0;
            reply_q.delete();
        end else begin
            // result side first so a beat is never matched against its own request
            if (m_valid && m_ready) begin
                got.read_value = m_read_value;
                got.status     = status_t'(m_status);
                got.count      = m_count;
                if (reply_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("[ilir chk] result beat %0d with no request pending: %p",
                                 reply_beats, got);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status
                            || got.count !== want.count) begin
                        if (fail_count < 10)
                            $display({"[ilir chk] result beat %0d: expected read_value %0d ",
                                      "status %0d count %0d, got read_value %0d status %0d ",
                                      "count %0d"},
                                     reply_beats, want.read_value, want.status, want.count,
                                     got.read_value, got.status, got.count);
                        fail_count++;
                    end
                end
                reply_beats++;
            end
            if (s_valid && s_ready)
                reply_q.push_back(predict_list_op(action_t'(s_action), int'(s_index), s_value));
        end
        replies_owed = reply_q.size();
        list_len     = n_words;
    end

endmodule

// File: bench/tb_indexed_list_insert_remove.sv
`timescale 1ns / 100ps

module tb_indexed_list_insert_remove;
    import ilir_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int CW             = $clog2(CAPACITY + 1);
    localparam int PHASE_BEATS    = 225;   // four phases, about 900 random beats
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

    logic                       aclk = 1'b0;
    logic                       aresetn;

    // request channel
    logic                       s_valid;
    logic                       s_ready;
    logic [ACTION_W-1:0]        s_action;
    logic [CW-1:0]              s_index;
    logic signed [WORD_W-1:0]   s_value;

    // result channel
    logic                       m_valid;
    logic                       m_ready;
    logic signed [WORD_W-1:0]   m_read_value;
    logic [STATUS_W-1:0]        m_status;
    logic [CW-1:0]              m_count;

    int fail_count;
    int replies_owed;
    int list_len;

    // idling per phase: none, sender idle, receiver stalls, both
    int send_idle_by_phase  [4] = '{0, 75, 0, 28};
    int recv_stall_by_phase [4] = '{0, 0, 75, 28};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    bit growing        = 1'b1;  // random part drifts toward full, then toward empty

    indexed_list_insert_remove #(
        .CAPACITY     (CAPACITY)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    ilir_list_checker #(
        .CAPACITY     (CAPACITY),
        .CW           (CW)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count),
        .fail_count   (fail_count),
        .replies_owed (replies_owed),
        .list_len     (list_len)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver backpressure, redrawn every cycle on the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: too long without a beat on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[indexed_list_insert_remove] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called on a falling edge; returns on the falling edge after the beat is taken
    // valid is written once per edge: either dropped for an idle cycle or raised
    task automatic send_request(input action_t op, input int pos,
                                input logic signed [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= op;
        s_index  <= CW'(pos);
        s_value  <= word;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // sender goes quiet until every outstanding result beat is back
    // always waits for a falling edge first so valid is not rewritten in this step
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        do @(negedge aclk); while (replies_owed != 0);
    endtask

    // mostly well-formed requests against the current length, some out of range
    task automatic random_request();
        action_t                    op;
        int                         pick;
        int                         pos;
        int                         len;
        logic signed [WORD_W-1:0]   word;
        len = list_len;
        // linger at full or empty for a few beats before turning around
        if (len == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
        else if (len == 0 && $urandom_range(0, 1) == 0) growing = 1'b1;
        pick = $urandom_range(0, 99);
        if (growing)
            op = pick < 30 ? ACT_APPEND : pick < 60 ? ACT_INSERT :
                 pick < 72 ? ACT_REMOVE : pick < 86 ? ACT_GET : ACT_SET;
        else
            op = pick < 40 ? ACT_REMOVE : pick < 50 ? ACT_APPEND :
                 pick < 60 ? ACT_INSERT : pick < 80 ? ACT_GET : ACT_SET;
        if (len == 0 || $urandom_range(0, 9) == 0) pos = $urandom_range(0, CAPACITY);
        else if (op == ACT_INSERT) pos = $urandom_range(0, len);
        else pos = $urandom_range(0, len - 1);
        case ($urandom_range(0, 15))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7fff_ffff;
            2:       word = '0;
            3:       word = '1;
            default: word = $urandom;
        endcase
        send_request(op, pos, word);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_action = '0;
        s_index  = '0;
        s_value  = '0;
        m_ready  = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, no idling
        // empty list: every indexed action is out of range
        send_request(ACT_GET,    0,  32'sd0);
        send_request(ACT_SET,    0,  32'sd7);
        send_request(ACT_REMOVE, 0,  32'sd0);
        send_request(ACT_INSERT, 1,  32'sd9);
        send_request(ACT_INSERT, 64, 32'sd9);
        // build min, 0, max, -1, pattern through front, middle and end inserts
        send_request(ACT_INSERT, 0,  32'h8000_0000);
        send_request(ACT_APPEND, 0,  32'h7fff_ffff);
        send_request(ACT_APPEND, 0,  -32'sd1);
        send_request(ACT_INSERT, 1,  32'sd0);
        send_request(ACT_INSERT, 4,  32'h5555_5555);
        send_request(ACT_GET,    0,  32'sd0);
        send_request(ACT_GET,    4,  32'sd0);
        send_request(ACT_GET,    5,  32'sd0);
        send_request(ACT_SET,    2,  32'haaaa_aaaa);
        send_request(ACT_GET,    2,  32'sd0);
        // remove from the front, the tail and the middle
        send_request(ACT_REMOVE, 0,  32'sd0);
        send_request(ACT_REMOVE, 3,  32'sd0);
        send_request(ACT_REMOVE, 1,  32'sd0);
        send_request(ACT_GET,    64, 32'sd0);
        send_request(ACT_SET,    3,  32'sd1);
        send_request(ACT_REMOVE, 1,  32'sd0);
        send_request(ACT_REMOVE, 0,  32'sd0);
        send_request(ACT_APPEND, 0,  32'sd1);
        send_request(ACT_REMOVE, 0,  32'sd0);
        wait_for_replies();

        // random part, one idling profile per phase
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // sender holds off mid-phase until the pipe is empty
                if (n == PHASE_BEATS / 2) wait_for_replies();
                random_request();
            end
            wait_for_replies();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_replies();
        // keep the clock running to catch any stray result beat
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && replies_owed == 0) begin
            $display("[indexed_list_insert_remove] OK");
        end else begin
            $display("[indexed_list_insert_remove] ERROR");
        end
        $finish;
    end

endmodule
